// ----- hw/rtl/sorted_priority_list_defines.svh -----
// Assertion macros for the sorted priority list RTL.
`ifndef SORTED_PRIORITY_LIST_DEFINES_SVH
`define SORTED_PRIORITY_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst is high.
`define SPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SPL_ASSERT_IMP(lbl, ante, cons, msg)
`define SPL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/spl_pkg.sv -----
// Types and constants for the sorted priority list.
package spl_pkg;

  localparam int CAPACITY = 16;
  localparam int HeldW    = $clog2(CAPACITY + 1);
  localparam int IdxW     = $clog2(CAPACITY);
  localparam int ValW     = 32;
  localparam int CountW   = 5;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_MAX = 2'd1,
    CMD_POP_MIN = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Data one cell shows its neighbours.
  typedef struct packed {
    logic [ValW-1:0] val;
    logic            occ;
    logic            ge;
  } cell_link_t;

  // Broadcast control, already qualified by accept, full and empty.
  typedef struct packed {
    logic            ins;
    logic            pop_max;
    logic            pop_min;
    logic            clear;
    logic [ValW-1:0] value;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/spl_if.sv -----
// Request and response channels of the sorted priority list.
interface spl_req_if
  import spl_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  logic [ValW-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface spl_rsp_if
  import spl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ValW-1:0]   popped_value;
  logic              popped_valid;
  logic [1:0]        status;
  logic [CountW-1:0] count;

  modport source (output valid, popped_value, popped_valid, status, count, input ready);
  modport sink   (input valid, popped_value, popped_valid, status, count, output ready);
endinterface

// ----- hw/rtl/spl_cell.sv -----
// One cell of the sorted chain: a value, its occupancy flag and the shift rules.
module spl_cell
  import spl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t self
);

  logic [ValW-1:0] val;
  logic [ValW-1:0] val_next;
  logic            occ;
  logic            occ_next;
  logic            ge;

  // Keeps its place on insert: held and not below the new value.
  assign ge = occ && ($signed(val) >= $signed(ctl.value));

  assign self.val = val;
  assign self.occ = occ;
  assign self.ge  = ge;

  always_comb begin
    val_next = val;
    occ_next = occ;
    priority if (ctl.clear) begin
      occ_next = 1'b0;
    end else if (ctl.ins) begin
      if (!ge) begin
        if (left.ge) begin
          val_next = ctl.value;
          occ_next = 1'b1;
        end else begin
          val_next = left.val;
          occ_next = left.occ;
        end
      end
    end else if (ctl.pop_max) begin
      val_next = right.val;
      occ_next = right.occ;
    end else if (ctl.pop_min) begin
      // the tail cell drops out
      if (occ && !right.occ) occ_next = 1'b0;
    end else begin
      // idle: hold
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ----- hw/rtl/sorted_priority_list.sv -----
// Sorted priority list: up to CAPACITY signed values kept largest first in a
// chain of cells.
// req carries one command per request (insert, pop largest, pop smallest,
// clear) with a value that only insert uses. rsp returns one response per
// request: the popped value and its valid flag, a status (ok, pop on empty,
// insert dropped because full) and the count held after the command.
// Every cell compares the broadcast value in the same cycle and shifts from
// its neighbour, so a request is applied in the cycle it is accepted and
// the response sits in the output register from the next cycle on.
// Throughput is one request per cycle while rsp is taken. Pop smallest
// reads the tail cell through one select over the chain.
// When rsp stalls, the response register holds and req.ready stays low
// until the response is taken; a request is accepted in the same cycle the
// waiting response leaves.
// Reset empties the store (all occupancy flags and the count clear) and
// drops any pending response; cell values are not reset.
module sorted_priority_list
  import spl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  spl_req_if.sink      req,
  spl_rsp_if.source    rsp
);

`include "sorted_priority_list_defines.svh"

  logic [HeldW-1:0]  held;
  logic [HeldW-1:0]  held_next;
  logic [HeldW-1:0]  held_m1;
  logic [IdxW-1:0]   tail_idx;
  logic              accept;
  logic              full;
  logic              empty;
  cmd_e              cmd;
  cell_ctl_t         ctl;
  cell_link_t        lnk [CAPACITY];
  cell_link_t        left_edge;
  cell_link_t        right_edge;
  logic [CAPACITY-1:0] occ_vec;

  logic              out_valid;
  logic [ValW-1:0]   out_value;
  logic              out_pvalid;
  status_e           out_status;
  logic [CountW-1:0] out_count;

  logic [ValW-1:0]   value_next;
  logic              pvalid_next;
  status_e           status_next;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cmd       = cmd_e'(req.cmd);
  assign full      = (held == HeldW'(CAPACITY));
  assign empty     = (held == '0);
  assign held_m1   = held - HeldW'(1);
  assign tail_idx  = held_m1[IdxW-1:0];

  assign ctl.ins     = accept && (cmd == CMD_INSERT) && !full;
  assign ctl.pop_max = accept && (cmd == CMD_POP_MAX) && !empty;
  assign ctl.pop_min = accept && (cmd == CMD_POP_MIN) && !empty;
  assign ctl.clear   = accept && (cmd == CMD_CLEAR);
  assign ctl.value   = req.value;

  // Head sees a neighbour that always keeps its place; tail sees nothing held.
  assign left_edge.val  = '0;
  assign left_edge.occ  = 1'b1;
  assign left_edge.ge   = 1'b1;
  assign right_edge.val = '0;
  assign right_edge.occ = 1'b0;
  assign right_edge.ge  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t l_in;
    cell_link_t r_in;
    if (i == 0) begin : g_head
      assign l_in = left_edge;
    end else begin : g_mid_l
      assign l_in = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_in = right_edge;
    end else begin : g_mid_r
      assign r_in = lnk[i+1];
    end
    spl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (l_in),
      .right (r_in),
      .self  (lnk[i])
    );
    assign occ_vec[i] = lnk[i].occ;
  end

  always_comb begin
    held_next   = held;
    value_next  = '0;
    pvalid_next = 1'b0;
    status_next = ST_OK;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) status_next = ST_FULL;
        else      held_next   = held + HeldW'(1);
      end
      CMD_POP_MAX: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          value_next  = lnk[0].val;
          pvalid_next = 1'b1;
          held_next   = held_m1;
        end
      end
      CMD_POP_MIN: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          value_next  = lnk[tail_idx].val;
          pvalid_next = 1'b1;
          held_next   = held_m1;
        end
      end
      CMD_CLEAR: begin
        held_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value  <= value_next;
      out_pvalid <= pvalid_next;
      out_status <= status_next;
      out_count  <= CountW'(held_next);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_value;
  assign rsp.popped_valid = out_pvalid;
  assign rsp.status       = out_status;
  assign rsp.count        = out_count;

  `SPL_ASSERT_IMP(a_occ_matches_held, 1'b1, $countones(occ_vec) == held, "occupancy flags disagree with count")
  `SPL_ASSERT_IMP(a_occ_prefix, 1'b1, (occ_vec & (occ_vec + CAPACITY'(1))) == '0, "occupied cells not contiguous from the head")
  `SPL_ASSERT_NXT(a_pop_shrinks, ctl.pop_max || ctl.pop_min, held == $past(held) - HeldW'(1), "pop did not shrink the store")
  `SPL_ASSERT_IMP(a_no_accept_stalled, out_valid && !rsp.ready, !accept, "request taken while response stalled")

  for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order_chk
    `SPL_ASSERT_IMP(a_sorted, lnk[j].occ && lnk[j+1].occ, $signed(lnk[j].val) >= $signed(lnk[j+1].val), "chain out of order")
  end

endmodule
